FILE: hw/rtl/dshot_erpm_telemetry_decoder_macros.svh
// assertion macros shared by the decoder checkers
// no dependencies; included by the checker file
`ifndef DSHOT_ERPM_TELEMETRY_DECODER_MACROS_SVH
`define DSHOT_ERPM_TELEMETRY_DECODER_MACROS_SVH

// same-cycle implication
`define DSHOT_ERPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSHOT_ERPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dshot_erpm_pkg.sv
// shared types, constants and the inverse gcr table for the erpm telemetry decoder
// no dependencies
package dshot_erpm_pkg;

   localparam int FRAME_BITS  = 21;
   localparam int COUNT_W     = 5;
   localparam int DIVIDEND_W  = 26;
   localparam int DIVISOR_W   = 16;
   localparam int STEP_W      = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGNET_COUNT = 2'd1;

   localparam logic [9:0] BIT_LENGTH_RESET   = 10'd64;
   localparam logic [7:0] MAGNET_COUNT_RESET = 8'd14;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_SHORT       = 3'd1;
   localparam logic [2:0] STATUS_BAD_GCR     = 3'd2;
   localparam logic [2:0] STATUS_BAD_CSUM    = 3'd3;
   localparam logic [2:0] STATUS_BUSY        = 3'd4;
   localparam logic [2:0] STATUS_ZERO_PERIOD = 3'd5;

   localparam logic [4:0]  GCR_BAD   = 5'h10;
   localparam logic [11:0] EDT_BUSY  = 12'hFFF;
   localparam logic [3:0]  CSUM_GOOD = 4'hF;
   localparam logic [DIVIDEND_W-1:0] US_PER_MINUTE = 26'd60000000;

   localparam logic [STEP_W-1:0] SHORT_STEPS = 5'd16;
   localparam logic [STEP_W-1:0] LONG_STEPS  = 5'd26;

   typedef struct packed {
      logic        pulse_level;
      logic [14:0] duration_ticks;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] erpm;
      logic [15:0] shaft_rpm;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
      logic [STEP_W-1:0]     steps;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [DIVISOR_W-1:0] period;
   } dec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEG_DIV,
      ST_DECODE,
      ST_ERPM_DIV,
      ST_RPM_DIV,
      ST_RESULT
   } state_type;

   function automatic logic [4:0] gcr_inverse(input logic [4:0] code);
      logic [4:0] nib;
      unique case (code)
         5'd9:    nib = 5'h9;
         5'd10:   nib = 5'hA;
         5'd11:   nib = 5'hB;
         5'd13:   nib = 5'hD;
         5'd14:   nib = 5'hE;
         5'd15:   nib = 5'hF;
         5'd18:   nib = 5'h2;
         5'd19:   nib = 5'h3;
         5'd21:   nib = 5'h5;
         5'd22:   nib = 5'h6;
         5'd23:   nib = 5'h7;
         5'd25:   nib = 5'h0;
         5'd26:   nib = 5'h8;
         5'd27:   nib = 5'h1;
         5'd29:   nib = 5'h4;
         5'd30:   nib = 5'hC;
         default: nib = GCR_BAD;
      endcase
      return nib;
   endfunction

endpackage

FILE: hw/rtl/dshot_erpm_telemetry_decoder.sv
// Bidirectional dshot erpm telemetry decoder. Each request word is one line segment; it is
// turned into round(duration / bit length) bits by one shared restoring divider that yields one
// quotient bit per cycle, and the next word is taken only once that division is done. A segment
// that ends a frame also decodes the 21-bit reply and, for a good frame, runs a 26-step division
// for erpm and, with at least two magnets, a 16-step division for shaft rpm; the response word
// is then loaded into the output register and the next word can follow (a frame with an error
// status skips both divisions, a good frame with fewer than two magnets the second). The
// response word sits in an output register, so a new request can be taken while it waits; a
// second finished frame waits until that register is free. Configuration writes take effect at
// once and are meant for idle time.
// depends on dshot_erpm_pkg, dshot_erpm_divider and dshot_erpm_gcr_decode
module dshot_erpm_telemetry_decoder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  dshot_erpm_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output dshot_erpm_pkg::rsp_type                rsp_data,
   input  logic                                   csr_we,
   input  logic [dshot_erpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dshot_erpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import dshot_erpm_pkg::*;

   localparam logic [FRAME_BITS-1:0] FRAME_ONE = FRAME_BITS'(1);

   state_type             state_ff, state_in;
   logic [9:0]            bit_length_ff, bit_length_in;
   logic [7:0]            magnet_count_ff, magnet_count_in;
   logic [FRAME_BITS-1:0] bit_shift_ff, bit_shift_in;
   logic [COUNT_W-1:0]    bit_count_ff, bit_count_in;
   logic                  level_ff, level_in;
   logic                  end_ff, end_in;
   rsp_type               work_ff, work_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   div_req_type           div_req;
   div_rsp_type           div_rsp;
   dec_type               dec;

   logic [9:0]            bit_length_eff;
   logic [15:0]           seg_num;
   logic [COUNT_W-1:0]    room;
   logic [COUNT_W-1:0]    add_n;
   logic [FRAME_BITS-1:0] fill_mask;
   logic                  rsp_load;

   dshot_erpm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dshot_erpm_gcr_decode u_gcr_decode (
      .frame_bits  (bit_shift_ff),
      .frame_count (bit_count_ff),
      .dec         (dec)
   );

   // zero bit length acts as one tick
   assign bit_length_eff = (bit_length_ff == '0) ? 10'd1 : bit_length_ff;
   assign seg_num        = {1'b0, req_data.duration_ticks} + {7'b0, bit_length_eff[9:1]};
   assign room           = COUNT_W'(FRAME_BITS) - bit_count_ff;
   assign add_n          = (div_rsp.quotient[15:0] > {11'b0, room}) ?
                           room : div_rsp.quotient[COUNT_W-1:0];
   assign fill_mask      = (FRAME_ONE << add_n) - FRAME_ONE;

   always_comb begin
      state_in     = state_ff;
      bit_shift_in = bit_shift_ff;
      bit_count_in = bit_count_ff;
      level_in     = level_ff;
      end_in       = end_ff;
      work_in      = work_ff;
      div_req      = '0;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               level_in         = req_data.pulse_level;
               end_in           = req_data.frame_end;
               div_req.start    = 1'b1;
               div_req.dividend = {seg_num, 10'b0};
               div_req.divisor  = {6'b0, bit_length_eff};
               div_req.steps    = SHORT_STEPS;
               state_in         = ST_SEG_DIV;
            end
         end
         ST_SEG_DIV: begin
            if (div_rsp.done) begin
               bit_shift_in = (bit_shift_ff << add_n) | (level_ff ? fill_mask : '0);
               bit_count_in = bit_count_ff + add_n;
               state_in     = end_ff ? ST_DECODE : ST_IDLE;
            end
         end
         ST_DECODE: begin
            bit_shift_in   = '0;
            bit_count_in   = '0;
            work_in        = '0;
            work_in.status = dec.status;
            if (dec.status == STATUS_OK) begin
               div_req.start    = 1'b1;
               div_req.dividend = US_PER_MINUTE;
               div_req.divisor  = dec.period;
               div_req.steps    = LONG_STEPS;
               state_in         = ST_ERPM_DIV;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_ERPM_DIV: begin
            if (div_rsp.done) begin
               work_in.erpm = div_rsp.quotient[15:0];
               if (magnet_count_ff >= 8'd2) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {div_rsp.quotient[15:0], 10'b0};
                  div_req.divisor  = {9'b0, magnet_count_ff[7:1]};
                  div_req.steps    = SHORT_STEPS;
                  state_in         = ST_RPM_DIV;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_RPM_DIV: begin
            if (div_rsp.done) begin
               work_in.shaft_rpm = div_rsp.quotient[15:0];
               state_in          = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      bit_length_in   = bit_length_ff;
      magnet_count_in = magnet_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BIT_LENGTH:   bit_length_in   = csr_data;
            CSR_MAGNET_COUNT: magnet_count_in = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in = rsp_load ? work_ff : rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         bit_length_ff   <= BIT_LENGTH_RESET;
         magnet_count_ff <= MAGNET_COUNT_RESET;
         bit_shift_ff    <= '0;
         bit_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bit_length_ff   <= bit_length_in;
         magnet_count_ff <= magnet_count_in;
         bit_shift_ff    <= bit_shift_in;
         bit_count_ff    <= bit_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      end_ff      <= end_in;
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/dshot_erpm_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on dshot_erpm_pkg
module dshot_erpm_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  dshot_erpm_pkg::div_req_type div_req,
   output dshot_erpm_pkg::div_rsp_type div_rsp
);
   import dshot_erpm_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     count_ff, count_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;
   logic                  borrow;

   assign shifted = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign borrow  = diff[DIVISOR_W+1];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      if (div_req.start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = div_req.steps;
         num_in   = div_req.dividend;
         den_in   = div_req.divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
         num_in   = {num_ff[DIVIDEND_W-2:0], ~borrow};
         count_in = count_ff - 1'b1;
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

FILE: hw/rtl/dshot_erpm_gcr_decode.sv
// frame decode: transition and gcr decoding, length, checksum, busy and period checks
// depends on dshot_erpm_pkg
module dshot_erpm_gcr_decode (
   input  logic [dshot_erpm_pkg::FRAME_BITS-1:0] frame_bits,
   input  logic [dshot_erpm_pkg::COUNT_W-1:0]    frame_count,
   output dshot_erpm_pkg::dec_type               dec
);
   import dshot_erpm_pkg::*;

   logic [FRAME_BITS-2:0] gcr;
   logic [4:0]            nib [4];
   logic [15:0]           word;
   logic                  bad;
   logic [3:0]            csum;
   logic [11:0]           edt;
   logic [DIVISOR_W-1:0]  period;

   assign gcr = frame_bits[FRAME_BITS-2:0] ^ frame_bits[FRAME_BITS-1:1];

   always_comb begin
      bad  = 1'b0;
      word = '0;
      for (int i = 0; i < 4; i++) begin
         nib[i]          = gcr_inverse(gcr[5*i +: 5]);
         word[4*i +: 4]  = nib[i][3:0];
         bad             = bad | nib[i][4];
      end
   end

   assign csum   = word[3:0] ^ word[7:4] ^ word[11:8] ^ word[15:12];
   assign edt    = word[15:4];
   assign period = {7'b0, edt[8:0]} << edt[11:9];

   always_comb begin
      dec.period = period;
      priority if (frame_count != COUNT_W'(FRAME_BITS)) begin
         dec.status = STATUS_SHORT;
      end else if (bad) begin
         dec.status = STATUS_BAD_GCR;
      end else if (csum != CSUM_GOOD) begin
         dec.status = STATUS_BAD_CSUM;
      end else if (edt == EDT_BUSY) begin
         dec.status = STATUS_BUSY;
      end else if (period == '0) begin
         dec.status = STATUS_ZERO_PERIOD;
      end else begin
         dec.status = STATUS_OK;
      end
   end

endmodule

FILE: hw/rtl/dshot_erpm_checker.sv
// port-level checks for the erpm telemetry decoder, bound to the top level
// depends on dshot_erpm_pkg and dshot_erpm_telemetry_decoder_macros.svh
`include "dshot_erpm_telemetry_decoder_macros.svh"

module dshot_erpm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input dshot_erpm_pkg::rsp_type rsp_data
);
   import dshot_erpm_pkg::*;

   `DSHOT_ERPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response word dropped or changed while stalled")
   `DSHOT_ERPM_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && (rsp_data.status != STATUS_OK), (rsp_data.erpm == '0) && (rsp_data.shaft_rpm == '0), "error response carries nonzero rpm")
   `DSHOT_ERPM_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_data.status <= STATUS_ZERO_PERIOD, "response status out of range")
   `DSHOT_ERPM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready again right after taking a segment")

endmodule

bind dshot_erpm_telemetry_decoder dshot_erpm_checker u_checker (.*);
